>>> design/spq_pkg.sv
// shared types and constants of the segmented pcm quantizer
package spq_pkg;

   localparam int NUM_SEGMENTS  = 8;
   localparam int SEG_W         = $clog2(NUM_SEGMENTS);
   localparam int SAMPLE_W      = 31;
   localparam int MAG_W         = 30;
   localparam int STEP_INDEX_W  = 23;
   localparam int CODEWORD_W    = 16;
   localparam int TOTAL_BITS_W  = 5;
   localparam int STEP_BITS_W   = 4;
   localparam int CSR_DATA_W    = 5;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [TOTAL_BITS_W-1:0] TOTAL_BITS_RESET = 5'd8;
   localparam logic [STEP_BITS_W-1:0]  STEP_BITS_RESET  = 4'd4;
   localparam logic [TOTAL_BITS_W-1:0] TOTAL_BITS_MIN   = 5'd8;
   localparam logic [TOTAL_BITS_W-1:0] TOTAL_BITS_MAX   = 5'd16;

   typedef enum logic {
      CSR_TOTAL_BITS = 1'b0,
      CSR_STEP_BITS  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [TOTAL_BITS_W-1:0] total_bits;
      logic [STEP_BITS_W-1:0]  step_bits;
   } cfg_type;

   typedef struct packed {
      logic             error;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } cls_type;

endpackage

>>> design/segmented_pcm_quantizer.sv
// top level of the segmented pcm quantizer
// an item taken passes through the queue, then the back end output register; one cycle of strobe
// throughput: one item per cycle, set by the back end draining the queue
// busy rises only when the queue is full, which does not happen while results flow out
// the receiver cannot stall, so every queued item leaves in the cycle after it arrives
// reset is synchronous: clears queue and strobe, sets total_bits to 8 and step_bits to 4
module segmented_pcm_quantizer #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [spq_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [spq_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output logic                                rsp_strobe,
   output logic                                rsp_error,
   output logic                                rsp_sign_bit,
   output logic [spq_pkg::SEG_W-1:0]           rsp_segment,
   output logic [spq_pkg::STEP_INDEX_W-1:0]    rsp_step_index,
   output logic signed [spq_pkg::SAMPLE_W-1:0] rsp_level,
   output logic [spq_pkg::CODEWORD_W-1:0]      rsp_codeword
);
   import spq_pkg::*;

   logic [TOTAL_BITS_W-1:0] total_bits_ff, total_bits_in;
   logic [STEP_BITS_W-1:0]  step_bits_ff, step_bits_in;
   cfg_type                 cfg;
   cls_type                 front_cls;
   cls_type                 queue_cls;
   logic                    queue_empty;
   logic                    queue_full;
   logic                    accept;

   always_comb begin
      total_bits_in = total_bits_ff;
      step_bits_in  = step_bits_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TOTAL_BITS: total_bits_in = csr_write_data[TOTAL_BITS_W-1:0];
            CSR_STEP_BITS:  step_bits_in  = csr_write_data[STEP_BITS_W-1:0];
            default:        total_bits_in = total_bits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_bits_ff <= TOTAL_BITS_RESET;
         step_bits_ff  <= STEP_BITS_RESET;
      end else begin
         total_bits_ff <= total_bits_in;
         step_bits_ff  <= step_bits_in;
      end
   end

   assign cfg.total_bits = total_bits_ff;
   assign cfg.step_bits  = step_bits_ff;
   assign busy           = queue_full;
   assign accept         = start && !queue_full;

   spq_front u_front (
      .sample (req_sample),
      .cfg    (cfg),
      .cls    (front_cls)
   );

   spq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_cls),
      .pop       (!queue_empty),
      .pop_data  (queue_cls),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   spq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (!queue_empty),
      .cls            (queue_cls),
      .cfg            (cfg),
      .rsp_strobe     (rsp_strobe),
      .rsp_error      (rsp_error),
      .rsp_sign_bit   (rsp_sign_bit),
      .rsp_segment    (rsp_segment),
      .rsp_step_index (rsp_step_index),
      .rsp_level      (rsp_level),
      .rsp_codeword   (rsp_codeword)
   );

endmodule

>>> design/spq_front.sv
// front end: sign and magnitude split, range and configuration check
module spq_front (
   input  logic signed [spq_pkg::SAMPLE_W-1:0] sample,
   input  spq_pkg::cfg_type                    cfg,
   output spq_pkg::cls_type                    cls
);
   import spq_pkg::*;

   logic [SAMPLE_W-1:0]     raw;
   logic [SAMPLE_W-1:0]     mag_full;
   logic [5:0]              limit;
   logic                    cfg_bad;
   logic                    over;

   always_comb begin
      raw      = sample;
      mag_full = raw[SAMPLE_W-1] ? (~raw + 31'd1) : raw;
      cfg_bad  = (cfg.total_bits < TOTAL_BITS_MIN) || (cfg.total_bits > TOTAL_BITS_MAX) ||
                 (cfg.step_bits == '0) || ({1'b0, cfg.step_bits} >= cfg.total_bits);
      limit    = {1'b0, cfg.total_bits} + {2'b0, cfg.step_bits} - 6'd1;
      over     = (mag_full >> limit[4:0]) != '0;
      cls.error = cfg_bad || over;
      cls.neg   = raw[SAMPLE_W-1];
      cls.mag   = mag_full[MAG_W-1:0];
   end

endmodule

>>> design/spq_queue.sv
// small queue between the front and back ends
module spq_queue #(
   parameter int DEPTH = spq_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  spq_pkg::cls_type push_data,
   input  logic             pop,
   output spq_pkg::cls_type pop_data,
   output logic             empty,
   output logic             full
);
   import spq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cls_type            entries [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign empty    = count_ff == '0;
   assign full     = count_ff == CNT_W'(DEPTH);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/spq_back.sv
// back end: segment search, step index, level and codeword, output register
module spq_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    item_valid,
   input  spq_pkg::cls_type                        cls,
   input  spq_pkg::cfg_type                        cfg,
   output logic                                    rsp_strobe,
   output logic                                    rsp_error,
   output logic                                    rsp_sign_bit,
   output logic [spq_pkg::SEG_W-1:0]               rsp_segment,
   output logic [spq_pkg::STEP_INDEX_W-1:0]        rsp_step_index,
   output logic signed [spq_pkg::SAMPLE_W-1:0]     rsp_level,
   output logic [spq_pkg::CODEWORD_W-1:0]          rsp_codeword
);
   import spq_pkg::*;

   logic [31:0]             mag32;
   logic [5:0]              b_sum;
   logic [4:0]              b;
   logic [NUM_SEGMENTS-2:0] q;
   logic [SEG_W-1:0]        seg;
   logic [4:0]              e;
   logic [4:0]              start_sh;
   logic [4:0]              seg_bits;
   logic [31:0]             start;
   logic [31:0]             lvl;
   logic [31:0]             idx;
   logic [31:0]             cw;

   logic                    strobe_ff;
   logic                    error_ff, error_in;
   logic                    sign_ff, sign_in;
   logic [SEG_W-1:0]        seg_ff, seg_in;
   logic [STEP_INDEX_W-1:0] idx_ff, idx_in;
   logic [SAMPLE_W-1:0]     level_ff, level_in;
   logic [CODEWORD_W-1:0]   cw_ff, cw_in;

   always_comb begin
      mag32 = {2'b0, cls.mag};
      b_sum = {1'b0, cfg.total_bits} + {2'b0, cfg.step_bits} - 6'd8;
      b     = b_sum[4:0];
      q     = (NUM_SEGMENTS - 1)'(mag32 >> b);
      seg   = '0;
      for (int i = 0; i < NUM_SEGMENTS - 1; i++) begin
         if (q[i]) begin
            seg = SEG_W'(i + 1);
         end
      end
      start_sh = b + {2'b0, seg} - 5'd1;
      start    = (seg == '0) ? 32'd0 : (32'd1 << start_sh);
      e        = (seg == '0) ? 5'd0 : (cfg.total_bits - 5'd8 + {2'b0, seg} - 5'd1);
      lvl      = mag32 & ~((32'd1 << e) - 32'd1);
      idx      = (mag32 - start) >> e;
      seg_bits = cfg.total_bits - {1'b0, cfg.step_bits} - 5'd1;
      cw       = ({31'b0, !cls.neg} << (cfg.total_bits - 5'd1))
               | (({29'b0, seg} & ((32'd1 << seg_bits) - 32'd1)) << cfg.step_bits)
               | (idx & ((32'd1 << cfg.step_bits) - 32'd1));

      error_in = cls.error;
      sign_in  = 1'b0;
      seg_in   = '0;
      idx_in   = '0;
      level_in = '0;
      cw_in    = '0;
      if (!cls.error) begin
         sign_in  = !cls.neg;
         seg_in   = seg;
         idx_in   = idx[STEP_INDEX_W-1:0];
         level_in = cls.neg ? SAMPLE_W'(32'd0 - lvl) : lvl[SAMPLE_W-1:0];
         cw_in    = cw[CODEWORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         error_ff <= error_in;
         sign_ff  <= sign_in;
         seg_ff   <= seg_in;
         idx_ff   <= idx_in;
         level_ff <= level_in;
         cw_ff    <= cw_in;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_error      = error_ff;
   assign rsp_sign_bit   = sign_ff;
   assign rsp_segment    = seg_ff;
   assign rsp_step_index = idx_ff;
   assign rsp_level      = level_ff;
   assign rsp_codeword   = cw_ff;

endmodule
